// ===== design/keypad_scan_debounce_repeat_unit_assert.svh =====
// Assertion macros for the keypad scanner checker.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef KEYPAD_SCAN_DEBOUNCE_REPEAT_UNIT_ASSERT_SVH
`define KEYPAD_SCAN_DEBOUNCE_REPEAT_UNIT_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define KSDR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset.
`define KSDR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication checked at every edge, reset included.
`define KSDR_ASSERT_ALL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/kpsd_pkg.sv =====
// Shared types and constants for the keypad scanner.
// No dependencies.
package kpsd_pkg;

  localparam int KEY_MATRIX_W = 12;
  localparam int KEY_CODE_W   = 4;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 16;
  localparam int TICK_W       = 16;

  localparam logic [TICK_W-1:0] DELAY_RESET  = 16'd100;
  localparam logic [TICK_W-1:0] PERIOD_RESET = 16'd20;

  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 4'd1;

  typedef struct packed {
    logic                    operation;
    logic [KEY_MATRIX_W-1:0] key_matrix;
  } in_t;

  typedef struct packed {
    logic [KEY_CODE_W-1:0] key_code;
    logic                  is_repeat;
  } out_t;

endpackage

// ===== design/keypad_scan_debounce_repeat_unit.sv =====
// Keypad matrix scanner with debounce and auto-repeat, top level.
// Depends on kpsd_pkg.
//
// Takes one request per cycle: a scan sample of the raw key matrix or a timer
// tick. A request is registered on entry, then evaluated against the scan
// state once the output register is free or draining, and its result (if
// any) lands in the output register. With out_ready held high one request is
// taken every cycle; a stalled result holds the output register while one
// more request waits in the entry register.
// Per column only the bottom pressed row counts. A scan is steady when some
// column matches the previous scan and is not empty; a steady scan reports the
// first newly pressed key (column-major) as a press, or, once the hold delay
// has run out, a repeat of the held key each time the period counter is zero.
// Ticks count both counters down. Config writes are taken every cycle
// (cfg_ready is tied high) and should only happen with the block idle;
// index 0 is the hold delay, index 1 the repeat period, others are ignored.
module keypad_scan_debounce_repeat_unit
  import kpsd_pkg::*;
#(
  parameter int COLUMNS = 3,
  parameter int ROWS    = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NKEYS = COLUMNS * ROWS;
  localparam int KEY_W = (NKEYS > 1) ? $clog2(NKEYS) : 1;

  // entry register
  in_t         req_r;
  logic        req_valid_r;

  // result register
  out_t        out_r;
  logic        out_valid_r;

  // config
  logic [TICK_W-1:0] delay_cfg_r;
  logic [TICK_W-1:0] period_cfg_r;

  // scan state
  logic [NKEYS-1:0]  last_sample_r;
  logic [NKEYS-1:0]  prev_snap_r;
  logic              armed_r;
  logic [KEY_CODE_W-1:0] held_key_r;
  logic [TICK_W-1:0] delay_cnt_r;
  logic [TICK_W-1:0] period_cnt_r;

  logic              advance;
  logic [NKEYS-1:0]  raw;
  logic [NKEYS-1:0]  cur;
  logic [NKEYS-1:0]  rise;
  logic              steady;
  logic              rise_any;
  logic [KEY_W-1:0]  first_idx;
  logic [KEY_W+KEY_CODE_W-1:0] first_ext;
  logic [KEY_CODE_W-1:0] first_code;
  logic              rpt_fire;
  logic              reload;
  logic              produce;

  // Request moves on when the result slot is free or being drained.
  assign advance   = req_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !req_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // Keys past the 12-bit field read as released.
  always_comb begin
    for (int i = 0; i < NKEYS; i++) begin
      raw[i] = (i < KEY_MATRIX_W) ? req_r.key_matrix[i % KEY_MATRIX_W] : 1'b0;
    end
  end

  // Keep only the bottom pressed row of each column; steady if any
  // non-empty column repeats the last scan.
  always_comb begin
    logic found;
    logic [ROWS-1:0] col_cur;
    logic [ROWS-1:0] col_last;
    cur    = '0;
    steady = 1'b0;
    for (int c = 0; c < COLUMNS; c++) begin
      found = 1'b0;
      for (int r = ROWS - 1; r >= 0; r--) begin
        cur[c*ROWS + r] = raw[c*ROWS + r] && !found;
        found = found | raw[c*ROWS + r];
      end
      col_cur  = cur[c*ROWS +: ROWS];
      col_last = last_sample_r[c*ROWS +: ROWS];
      if ((col_cur != '0) && (col_cur == col_last)) begin
        steady = 1'b1;
      end
    end
  end

  assign rise     = cur & ~prev_snap_r;
  assign rise_any = (rise != '0);

  // lowest newly risen key
  always_comb begin
    first_idx = '0;
    for (int k = NKEYS - 1; k >= 0; k--) begin
      if (rise[k]) begin
        first_idx = KEY_W'(k);
      end
    end
  end

  assign first_ext  = {{KEY_CODE_W{1'b0}}, first_idx};
  assign first_code = first_ext[KEY_CODE_W-1:0];

  // Repeat check runs before the first risen key is reached in scan order,
  // so it still reloads the period unless that key is key 0.
  assign rpt_fire = armed_r && (delay_cnt_r == '0) && (period_cnt_r == '0);
  assign reload   = rpt_fire && (!rise_any || (first_idx != '0));
  assign produce  = (req_r.operation == OP_SCAN) && steady && (rise_any || rpt_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
      delay_cfg_r   <= DELAY_RESET;
      period_cfg_r  <= PERIOD_RESET;
      last_sample_r <= '0;
      prev_snap_r   <= '0;
      armed_r       <= 1'b0;
      held_key_r    <= '0;
      delay_cnt_r   <= '0;
      period_cnt_r  <= '0;
    end else begin
      if (in_ready) begin
        req_valid_r <= in_valid;
      end
      if (in_valid && in_ready) begin
        req_r <= in_data;
      end

      if (cfg_valid) begin
        case (cfg_index)
          CFG_DELAY:  delay_cfg_r  <= cfg_data;
          CFG_PERIOD: period_cfg_r <= cfg_data;
          default: ;
        endcase
      end

      // slot refills on advance, otherwise drains on out_ready
      if (advance) begin
        out_valid_r <= produce;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (advance) begin
        if (req_r.operation == OP_TICK) begin
          if (delay_cnt_r != '0) begin
            delay_cnt_r <= delay_cnt_r - 1'b1;
          end
          if (period_cnt_r != '0) begin
            period_cnt_r <= period_cnt_r - 1'b1;
          end
        end else begin
          last_sample_r <= cur;
          if (steady) begin
            prev_snap_r <= cur;
            if (rise_any) begin
              held_key_r  <= first_code;
              armed_r     <= 1'b1;
              delay_cnt_r <= delay_cfg_r;
            end
            if (reload) begin
              period_cnt_r <= period_cfg_r;
            end
          end else begin
            armed_r      <= 1'b0;
            period_cnt_r <= '0;
            prev_snap_r  <= '0;
          end
        end
        if (produce) begin
          out_r.key_code  <= rise_any ? first_code : held_key_r;
          out_r.is_repeat <= !rise_any;
        end
      end
    end
  end

endmodule

// ===== design/kpsd_checker.sv =====
// Port-level checker for the keypad scanner, bound to the top level.
// Depends on kpsd_pkg and keypad_scan_debounce_repeat_unit_assert.svh.
`include "keypad_scan_debounce_repeat_unit_assert.svh"

module kpsd_checker
  import kpsd_pkg::*;
#(
  parameter int COLUMNS = 3,
  parameter int ROWS    = 4
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input in_t                   in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input out_t                  out_data,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NKEYS = COLUMNS * ROWS;

  // stalled result holds
  `KSDR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // input only backs up behind a waiting result
  `KSDR_ASSERT_IMP(a_in_stall, !in_ready, out_valid, "input stalled with no result pending")

  // issued code names a real key
  `KSDR_ASSERT_IMP(a_code_range, out_valid, (NKEYS > 16) || (out_data.key_code < NKEYS), "key code out of range")

  // reset empties the result register
  `KSDR_ASSERT_ALL(a_rst_empty, $past(!rst_n), !out_valid, "result valid right after reset")

endmodule

bind keypad_scan_debounce_repeat_unit kpsd_checker #(
  .COLUMNS(COLUMNS),
  .ROWS(ROWS)
) u_kpsd_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .in_data(in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data(out_data),
  .cfg_valid(cfg_valid),
  .cfg_ready(cfg_ready),
  .cfg_index(cfg_index),
  .cfg_data(cfg_data)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for keypad_scan_debounce_repeat_unit: directed and random
// scan/tick traffic, checked against an in-bench key event predictor. Depends on kpsd_pkg.
module tb_top;
  import kpsd_pkg::*;

  localparam int NUM_COLS      = 3;
  localparam int NUM_ROWS      = 4;
  localparam int NUM_KEYS      = NUM_COLS * NUM_ROWS;
  // Time for requests with no result to drain through the entry and result registers.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int LONG_HOLD     = 200;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  keypad_scan_debounce_repeat_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the scanner state and its registers.
  // ---------------------------------------------------------------------------
  logic [TICK_W-1:0]       shadow_delay;
  logic [TICK_W-1:0]       shadow_period;
  logic [KEY_MATRIX_W-1:0] prev_scan;    // filtered sample of the previous scan
  logic [KEY_MATRIX_W-1:0] rise_base;    // snapshot used to spot newly pressed keys
  logic                    repeat_on;
  logic [KEY_CODE_W-1:0]   held_code;
  logic [TICK_W-1:0]       delay_left;
  logic [TICK_W-1:0]       period_left;

  out_t pending_key_events[$];

  // Traffic shaping knobs: percent of cycles spent idle / stalled, plus a long receiver hold.
  int send_idle_pct;
  int rx_stall_pct;
  int rx_hold_req;
  int rx_hold_left;

  int error_count;
  int cycle_count;
  int requests_sent;
  int scans_sent;
  int ticks_sent;
  int presses_seen;
  int repeats_seen;

  // Per column only the bottom-most pressed row survives (highest row index).
  function automatic logic [KEY_MATRIX_W-1:0] bottom_row_per_column(
      input logic [KEY_MATRIX_W-1:0] raw);
    logic [KEY_MATRIX_W-1:0] keep;
    keep = '0;
    for (int c = 0; c < NUM_COLS; c++) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        if (raw[c*NUM_ROWS + r]) begin
          keep[c*NUM_ROWS +: NUM_ROWS] = '0;
          keep[c*NUM_ROWS + r] = 1'b1;
        end
      end
    end
    return keep;
  endfunction

  // Advances the predictor by one request; returns 1 when a key event is due.
  function automatic bit predict_key_event(input in_t req, output out_t ev);
    logic [KEY_MATRIX_W-1:0] cur;
    logic [KEY_MATRIX_W-1:0] rise;
    logic [NUM_ROWS-1:0]     col_now;
    bit                      steady;
    bit                      may_repeat;
    bit                      pressed;
    bit                      issued;
    ev      = '0;
    issued  = 1'b0;
    pressed = 1'b0;
    steady  = 1'b0;
    if (req.operation == OP_TICK) begin
      if (delay_left != 0) delay_left--;
      if (period_left != 0) period_left--;
      return 1'b0;
    end
    cur = bottom_row_per_column(req.key_matrix);
    for (int c = 0; c < NUM_COLS; c++) begin
      col_now = cur[c*NUM_ROWS +: NUM_ROWS];
      if (col_now != 0 && col_now == prev_scan[c*NUM_ROWS +: NUM_ROWS]) steady = 1'b1;
    end
    if (steady) begin
      rise       = cur & ~rise_base;
      rise_base  = cur;
      may_repeat = repeat_on && delay_left == 0;
      // Keys below the first new one still get the repeat check, so a press
      // that is not key 0 can reload the period counter on its way.
      for (int k = 0; k < NUM_KEYS && !pressed; k++) begin
        if (rise[k]) begin
          held_code    = KEY_CODE_W'(k);
          repeat_on    = 1'b1;
          delay_left   = shadow_delay;
          ev.key_code  = KEY_CODE_W'(k);
          ev.is_repeat = 1'b0;
          pressed      = 1'b1;
          issued       = 1'b1;
        end else if (may_repeat && period_left == 0) begin
          ev.key_code  = held_code;
          ev.is_repeat = 1'b1;
          period_left  = shadow_period;
          issued       = 1'b1;
        end
      end
    end else begin
      repeat_on   = 1'b0;
      period_left = '0;
      rise_base   = '0;
    end
    prev_scan = cur;
    return issued;
  endfunction

  function automatic logic [KEY_MATRIX_W-1:0] rand_matrix();
    return KEY_MATRIX_W'($urandom);
  endfunction

  // Mostly one key, sometimes two, now and then a random smear across the pad.
  function automatic logic [KEY_MATRIX_W-1:0] pick_keys();
    logic [KEY_MATRIX_W-1:0] k;
    k = '0;
    k[$urandom_range(NUM_KEYS-1)] = 1'b1;
    if ($urandom_range(3) == 0) k[$urandom_range(NUM_KEYS-1)] = 1'b1;
    if ($urandom_range(5) == 0) k = rand_matrix();
    return k;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver. Leaves in_valid high on return so that a back-to-back
  // request just replaces the payload in the same step; idle gaps and
  // wait_for_idle are the only places that lower it.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic op, input logic [KEY_MATRIX_W-1:0] keys);
    in_t  req;
    out_t ev;
    req.operation  = op;
    req.key_matrix = keys;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    if (predict_key_event(req, ev)) pending_key_events.push_back(ev);
    requests_sent++;
    if (op == OP_TICK) ticks_sent++;
    else scans_sent++;
  endtask

  task automatic scan(input logic [KEY_MATRIX_W-1:0] keys);
    send_request(OP_SCAN, keys);
  endtask

  // The matrix field rides along on ticks too; the block must ignore it.
  task automatic tick();
    send_request(OP_TICK, rand_matrix());
  endtask

  // Drops valid, waits for every predicted event, then lets the pipe empty
  // of requests that produce nothing.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (pending_key_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_DELAY) shadow_delay = val;
    else if (idx == CFG_PERIOD) shadow_period = val;
    @(posedge clk);
  endtask

  task automatic set_repeat_timing(input logic [TICK_W-1:0] hold_delay,
                                   input logic [TICK_W-1:0] rep_period);
    wait_for_idle();
    write_reg(CFG_DELAY, hold_delay);
    write_reg(CFG_PERIOD, rep_period);
  endtask

  // Random traffic built mostly from held-key sessions (press, hold with
  // ticks in between, roll-over and partial release), plus noise and bounce.
  task automatic random_sessions(input int n_items);
    int                      target;
    int                      n_scans;
    logic [KEY_MATRIX_W-1:0] keys;
    target = requests_sent + n_items;
    while (requests_sent < target) begin
      keys = pick_keys();
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5, 6: begin
          n_scans = $urandom_range(2, 10);
          repeat (n_scans) begin
            repeat ($urandom_range(3)) tick();
            if ($urandom_range(5) == 0) keys[$urandom_range(NUM_KEYS-1)] = 1'b1;
            else if ($urandom_range(7) == 0) keys &= rand_matrix();
            scan(keys);
          end
        end
        7, 8: begin
          repeat ($urandom_range(1, 6)) send_request(1'($urandom), rand_matrix());
        end
        default: begin
          // contact bounce: the pattern flickers against an open matrix
          repeat ($urandom_range(2, 6)) scan($urandom_range(1) ? keys : '0);
        end
      endcase
    end
  endtask

  task automatic run_phase(input logic [TICK_W-1:0] hold_delay,
                           input logic [TICK_W-1:0] rep_period,
                           input int idle_pct, input int stall_pct, input int n_items);
    set_repeat_timing(hold_delay, rep_period);
    send_idle_pct = idle_pct;
    rx_stall_pct  = stall_pct;
    random_sessions(n_items);
  endtask

  // ---------------------------------------------------------------------------
  // Named tests
  // ---------------------------------------------------------------------------

  // Reset timing (100/20): a first press, the column filter on a full matrix,
  // and a steady scan with nothing new.
  task automatic test_press_and_filter();
    tick();
    scan(12'h001);
    scan(12'h001);    // steady: press of key 0
    scan(12'hFFF);    // filters to 0x888, columns changed: not steady
    scan(12'hFFF);    // press of key 3, the lowest of the new bottom keys
    scan(12'hFFF);    // steady, nothing new, delay still running
  endtask

  // Zero period: once the wait is out every steady scan repeats.
  task automatic test_zero_period_repeat();
    set_repeat_timing(16'd2, 16'd0);
    scan(12'h020);
    scan(12'h020);    // press of key 5
    tick();
    tick();
    scan(12'h020);    // repeat
    scan(12'h020);    // repeat again, no period to wait out
  endtask

  // New key that is not first while a repeat is due, then a repeat of a key
  // that has already been let go while another column stays steady.
  task automatic test_repeat_corners();
    set_repeat_timing(16'd1, 16'd3);
    scan(12'h004);
    scan(12'h004);    // press of key 2
    tick();
    scan(12'h004);    // repeat of key 2, period reloaded
    repeat (3) tick();
    scan(12'h104);    // press of key 8, period reloaded on the way
    repeat (3) tick();
    scan(12'h004);    // key 8 released: still repeats key 8
  endtask

  // Both timing registers at zero; writes to unused indexes must not land.
  task automatic test_config_extremes();
    set_repeat_timing(16'd0, 16'd0);
    write_reg(CFG_IDX_W'(2), 16'hFFFF);
    write_reg('1, 16'h1234);
    tick();
    scan(12'h400);
    scan(12'h400);    // press of key 10
    scan(12'h400);    // immediate repeat
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so the
  // block fills and drops in_ready; afterwards the sender waits for a drain.
  task automatic test_output_backpressure();
    set_repeat_timing(16'd2, 16'd1);
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    rx_hold_req   = LONG_HOLD;
    random_sessions(40);
    wait_for_idle();
  endtask

  task automatic test_random_traffic();
    run_phase(16'd3, 16'd2, 0, 0, 250);
    run_phase(16'd0, 16'd0, 73, 0, 200);
    run_phase(16'hFFFF, 16'hFFFF, 0, 73, 150);
    run_phase(16'd5, 16'd1, 9, 9, 200);
    run_phase(TICK_W'($urandom_range(8)), TICK_W'($urandom_range(4)), 73, 73, 180);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a counted long hold on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Event checker: every accepted result against the oldest prediction.
  always @(posedge clk) begin : check_events
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_key_events.size() == 0) begin
        $error("unexpected key event: key_code %0d is_repeat %0d",
               out_data.key_code, out_data.is_repeat);
        error_count++;
      end else begin
        want = pending_key_events.pop_front();
        if (out_data.key_code !== want.key_code) begin
          $error("key_code: expected %0d, got %0d", want.key_code, out_data.key_code);
          error_count++;
        end
        if (out_data.is_repeat !== want.is_repeat) begin
          $error("is_repeat: expected %0d, got %0d", want.is_repeat, out_data.is_repeat);
          error_count++;
        end
        if (want.is_repeat) repeats_seen++;
        else presses_seen++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events outstanding",
               cycle_count, pending_key_events.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    rx_hold_req   = 0;
    rx_hold_left  = 0;
    error_count   = 0;
    cycle_count   = 0;
    requests_sent = 0;
    scans_sent    = 0;
    ticks_sent    = 0;
    presses_seen  = 0;
    repeats_seen  = 0;
    shadow_delay  = DELAY_RESET;
    shadow_period = PERIOD_RESET;
    prev_scan     = '0;
    rise_base     = '0;
    repeat_on     = 1'b0;
    held_code     = '0;
    delay_left    = '0;
    period_left   = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_press_and_filter();
    test_zero_period_repeat();
    test_repeat_corners();
    test_config_extremes();
    test_output_backpressure();
    test_random_traffic();
    wait_for_idle();

    if (pending_key_events.size() != 0) begin
      $error("%0d predicted key events never arrived", pending_key_events.size());
      error_count++;
    end
    $display("Sent %0d requests (%0d scans, %0d ticks); checked %0d presses and %0d repeats.",
             requests_sent, scans_sent, ticks_sent, presses_seen, repeats_seen);
    $display("Timing from reset defaults to zero and full scale, with stalls and a long hold.");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
